// ===== hdl/lisrc_pkg.sv =====
// Shared constants and control types for the linear interpolation rate converter.
`default_nettype none

package lisrc_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int RATE_W         = 18;
    localparam int PHASE_W        = 19;
    localparam int ACC_W          = SAMPLE_W + RATE_W;
    localparam int MAX_OUT_PER_IN = 16;
    localparam int RES_CNT_W      = $clog2(MAX_OUT_PER_IN + 1);
    localparam int OVF_SUM_W      = PHASE_W + RES_CNT_W + 1;
    localparam int DIV_CNT_W      = $clog2(RATE_W + 1);

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_INTERP = DIV_CNT_W'(SAMPLE_W);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD    = DIV_CNT_W'(RATE_W);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 1'b1;

    typedef struct packed {
        logic load_item;
        logic mul_a;
        logic mul_b;
        logic div_init_interp;
        logic div_init_mod;
        logic div_step;
        logic emit;
        logic fin_phase;
        logic fin_mod;
    } lisrc_cmd_t;

    typedef struct packed {
        logic more;
        logic f_below;
        logic out_free;
    } lisrc_status_t;

endpackage

`default_nettype wire

// ===== hdl/linear_interp_sample_rate_converter_core.sv =====
// Top level of the linear interpolation sample rate converter.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall | in_sample
//  out     | from blk  | out_valid/out_stall | out_sample, last_of_run, overflow
//  cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each result that an input beat yields costs one multiply pair, a pass of the shared
// divider and an emit; when results are dropped past sixteen, a remainder pass of the
// shared divider sets the phase for the next input.
// Reset sets both rates to 48000 and clears the previous sample and the phase.
// A stalled output holds the finished result while the controller waits to emit the next.
`default_nettype none

module linear_interp_sample_rate_converter_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [lisrc_pkg::SAMPLE_W-1:0] in_sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [lisrc_pkg::SAMPLE_W-1:0]      out_sample,
    output logic                                       last_of_run,
    output logic                                       overflow,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lisrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lisrc_pkg::RATE_W-1:0]          cfg_data
);
    import lisrc_pkg::*;

    lisrc_cmd_t    cmd;
    lisrc_status_t status;

    assign cfg_ready = 1'b1;

    lisrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lisrc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_sample   (in_sample),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_sample  (out_sample),
        .last_of_run (last_of_run),
        .overflow    (overflow)
    );

    // An accepted input keeps the block busy for at least the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted but block not busy afterwards");

    // The controller issues at most one datapath command per cycle.
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    // A result is never written over one that is still held by a stalled output.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && out_stall))
        else $error("result emitted over a stalled output beat");

    // Only an emit can raise the output valid.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !cmd.emit) |=> !out_valid)
        else $error("output valid rose without an emit");

endmodule

`default_nettype wire

// ===== hdl/lisrc_datapath.sv =====
// Datapath: rate registers, sample and phase state, multiplier, shared divider, output register.
`default_nettype none

module lisrc_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr,
    input  wire logic [lisrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lisrc_pkg::RATE_W-1:0]        cfg_data,
    input  wire logic signed [lisrc_pkg::SAMPLE_W-1:0] in_sample,
    input  wire lisrc_pkg::lisrc_cmd_t               cmd,
    output lisrc_pkg::lisrc_status_t                 status,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [lisrc_pkg::SAMPLE_W-1:0]    out_sample,
    output logic                                     last_of_run,
    output logic                                     overflow
);
    import lisrc_pkg::*;

    logic [RATE_W-1:0]    src_reg, src_next;
    logic [RATE_W-1:0]    dst_reg, dst_next;
    logic [SAMPLE_W-1:0]  prev_reg, prev_next;
    logic [SAMPLE_W-1:0]  cur_reg, cur_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [ACC_W-1:0]     sh_reg, sh_next;
    logic [RATE_W-1:0]    divisor_reg, divisor_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_sample_reg, out_sample_next;
    logic                 last_reg, last_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic [RATE_W-1:0]    src_eff, dst_eff;
    logic [RATE_W-1:0]    f_lo, diff;
    logic [SAMPLE_W-1:0]  up, uc;
    logic [SAMPLE_W-1:0]  mul_x;
    logic [RATE_W-1:0]    mul_y;
    logic [ACC_W-1:0]     prod;
    logic [OVF_SUM_W-1:0] ovf_sum;
    logic                 ovf_hit;
    logic [PHASE_W-1:0]   f_step;
    logic [RATE_W:0]      trial_in, trial;
    logic                 q_bit;
    logic                 out_take;

    // A rate register holding zero behaves as a rate of one.
    assign src_eff = (src_reg == '0) ? RATE_W'(1) : src_reg;
    assign dst_eff = (dst_reg == '0) ? RATE_W'(1) : dst_reg;

    // Phase is below the target rate whenever it is used as an interpolation offset.
    assign f_lo = phase_reg[RATE_W-1:0];
    assign diff = dst_eff - f_lo;

    // Offset binary turns the signed blend into an unsigned one with a bias of half scale.
    assign up = {~prev_reg[SAMPLE_W-1], prev_reg[SAMPLE_W-2:0]};
    assign uc = {~cur_reg[SAMPLE_W-1], cur_reg[SAMPLE_W-2:0]};

    assign mul_x = cmd.mul_b ? uc : up;
    assign mul_y = cmd.mul_b ? f_lo : diff;
    assign prod  = ACC_W'(mul_x) * ACC_W'(mul_y);

    assign ovf_sum = OVF_SUM_W'(phase_reg)
                   + OVF_SUM_W'(src_eff) * OVF_SUM_W'(MAX_OUT_PER_IN);
    assign ovf_hit = ovf_sum < OVF_SUM_W'(dst_eff);

    assign f_step = phase_reg + PHASE_W'(src_eff);

    // One restoring division step per cycle.
    assign trial_in = {rem_reg, sh_reg[ACC_W-1]};
    assign trial    = trial_in - {1'b0, divisor_reg};
    assign q_bit    = trial_in >= {1'b0, divisor_reg};

    assign out_take = out_valid_reg && !out_stall;

    assign status.f_below  = phase_reg < PHASE_W'(dst_eff);
    assign status.more     = status.f_below
                          && (res_cnt_reg != RES_CNT_W'(MAX_OUT_PER_IN));
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        src_next        = src_reg;
        dst_next        = dst_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        phase_next      = phase_reg;
        res_cnt_next    = res_cnt_reg;
        ovf_next        = ovf_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        sh_next         = sh_reg;
        divisor_next    = divisor_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        last_next       = last_reg;
        out_ovf_next    = out_ovf_reg;

        if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_SOURCE_RATE: src_next = cfg_data;
                REG_TARGET_RATE: dst_next = cfg_data;
            endcase
        end

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load_item)
        begin
            cur_next     = in_sample;
            ovf_next     = ovf_hit;
            res_cnt_next = '0;
        end

        if (cmd.mul_a)
        begin
            acc_next = prod;
        end

        if (cmd.mul_b)
        begin
            acc_next = acc_reg + prod;
        end

        if (cmd.div_init_interp)
        begin
            rem_next     = acc_reg[ACC_W-1:SAMPLE_W];
            sh_next      = {acc_reg[SAMPLE_W-1:0], {RATE_W{1'b0}}};
            divisor_next = dst_eff;
        end

        if (cmd.div_init_mod)
        begin
            rem_next     = '0;
            sh_next      = {diff, {SAMPLE_W{1'b0}}};
            divisor_next = src_eff;
        end

        if (cmd.div_step)
        begin
            rem_next = q_bit ? trial[RATE_W-1:0] : trial_in[RATE_W-1:0];
            sh_next  = {sh_reg[ACC_W-2:0], q_bit};
        end

        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = {~sh_reg[SAMPLE_W-1], sh_reg[SAMPLE_W-2:0]};
            last_next       = (res_cnt_reg == RES_CNT_W'(MAX_OUT_PER_IN - 1))
                           || (f_step >= PHASE_W'(dst_eff));
            out_ovf_next    = ovf_reg;
            phase_next      = f_step;
            res_cnt_next    = res_cnt_reg + RES_CNT_W'(1);
        end

        if (cmd.fin_phase)
        begin
            phase_next = phase_reg - PHASE_W'(dst_eff);
            prev_next  = cur_reg;
        end

        // Dropped results: the phase lands on the first multiple of the source rate
        // past the target rate, found from the remainder.
        if (cmd.fin_mod)
        begin
            phase_next = (rem_reg == '0) ? '0 : PHASE_W'(src_eff - rem_reg);
            prev_next  = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg       <= RATE_RESET;
            dst_reg       <= RATE_RESET;
            prev_reg      <= '0;
            phase_reg     <= '0;
            res_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            res_cnt_reg   <= res_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        ovf_reg        <= ovf_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        sh_reg         <= sh_next;
        divisor_reg    <= divisor_next;
        out_sample_reg <= out_sample_next;
        last_reg       <= last_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign last_of_run = last_reg;
    assign overflow    = out_ovf_reg;

endmodule

`default_nettype wire

// ===== hdl/lisrc_ctrl.sv =====
// Controller state machine sequencing multiply, divide and emit steps per input sample.
`default_nettype none

module lisrc_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire lisrc_pkg::lisrc_status_t  status,
    output lisrc_pkg::lisrc_cmd_t          cmd
);
    import lisrc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHECK    = 8'b0000_0010,
        S_MUL_B    = 8'b0000_0100,
        S_DIV_INIT = 8'b0000_1000,
        S_DIV      = 8'b0001_0000,
        S_EMIT     = 8'b0010_0000,
        S_MOD_DIV  = 8'b0100_0000,
        S_FIN_MOD  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (status.more)
                begin
                    cmd.mul_a  = 1'b1;
                    state_next = S_MUL_B;
                end
                else if (status.f_below)
                begin
                    cmd.div_init_mod = 1'b1;
                    div_cnt_next     = DIV_STEPS_MOD;
                    state_next       = S_MOD_DIV;
                end
                else
                begin
                    cmd.fin_phase = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init_interp = 1'b1;
                div_cnt_next        = DIV_STEPS_INTERP;
                state_next          = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_MOD_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = S_FIN_MOD;
                end
            end
            S_FIN_MOD:
            begin
                cmd.fin_mod = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire
